FILE: rtl/vgaxm_pkg.sv
// Shared constants and types for the VGA extension register bank mapper.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package vgaxm_pkg;

	// Default size of the extension register file.
	localparam int XREG_DEPTH_DEF = 256;

	// Beat widths on the two stream sides.
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 80;

	// Decoded I/O ports, after the mono/colour swap.
	localparam logic [15:0] PORT_MONO_IDX  = 16'h03B6;
	localparam logic [15:0] PORT_COLOR_IDX = 16'h03D6;
	localparam logic [15:0] PORT_SETUP     = 16'h0102;
	localparam logic [15:0] PORT_XSETUP    = 16'h0103;
	localparam logic [15:0] PORT_ID        = 16'h0104;
	localparam logic [15:0] PORT_OPTSEL    = 16'h46E8;
	localparam logic [11:0] MONO_GROUP     = 12'h03B;
	localparam logic [11:0] COLOR_GROUP    = 12'h03D;
	localparam logic [15:0] MONO_XOR       = 16'h0060;

	// Fixed read-back bytes.
	localparam logic [7:0] VERSION_BYTE = 8'h40;
	localparam logic [7:0] CONFIG_BYTE  = 8'h03;
	localparam logic [7:0] ID_BYTE      = 8'hA5;
	localparam logic [7:0] IDLE_BYTE    = 8'hFF;

	// Extension register indices with a fixed meaning.
	localparam logic [7:0] IDX_VERSION   = 8'h00;
	localparam logic [7:0] IDX_CONFIG    = 8'h01;
	localparam logic [7:0] REG_MAP       = 8'h0B;
	localparam logic [7:0] REG_START     = 8'h0C;
	localparam logic [7:0] REG_BANK0     = 8'h10;
	localparam logic [7:0] REG_BANK1     = 8'h11;
	localparam logic [7:0] REG_INTERLACE = 8'h28;
	localparam logic [7:0] REG_ENABLE    = 8'h70;

	// Bit positions in the extension setup byte.
	localparam int ENABLE_BIT = 7;
	localparam int SELECT_BIT = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input beat
		logic exec;   // decode, update state, read the register file
		logic form;   // load the output register
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/vgaxm_ctrl.sv
// Controller state machine of the VGA extension register bank mapper.
// Depends on vgaxm_pkg for the command struct.
`default_nettype none

module vgaxm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output vgaxm_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FORM
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   slot_free;

	// The output register is free when empty or being emptied this cycle.
	assign slot_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Commands to the datapath.
	assign cmd.load = s_tvalid && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.form = (state_q == ST_FORM) && slot_free;

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// A result beat is raised when formed and dropped once taken.
			if (state_q == ST_FORM && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FORM;
				end
				ST_FORM: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vgaxm_datapath.sv
// Datapath of the VGA extension register bank mapper: port decode, setup
// registers, extension register file with valid bits, bank offsets, output register.
// Depends on vgaxm_pkg.
`default_nettype none

module vgaxm_datapath #(
	parameter int XREG_DEPTH = vgaxm_pkg::XREG_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire vgaxm_pkg::cmd_t                  cmd,
	input  wire logic [vgaxm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic [0:0]                       s_tuser,
	output logic      [vgaxm_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int AW = $clog2(XREG_DEPTH);
	localparam logic [8:0] DEPTH = 9'(XREG_DEPTH);

	// Captured access.
	logic        mode_q;
	logic [15:0] port_q;
	logic [7:0]  wd_q;
	logic        c4_q;
	logic [1:0]  mm_q;
	logic        color_q;

	// Architectural state.
	logic [7:0]  idx_q;
	logic [7:0]  setup_q;
	logic [7:0]  xsetup_q;
	logic [2:0]  x0b_q;
	logic        x0c_q;
	logic [7:0]  x10_q;
	logic [7:0]  x11_q;
	logic        x28_q;
	logic        x70_q;

	// Register file and its valid bits.
	logic [7:0]            mem [XREG_DEPTH];
	logic [XREG_DEPTH-1:0] vld_q;
	logic [7:0]            mem_rd_q;
	logic                  mem_vld_q;

	// Results of the decode step.
	logic [7:0] rd_q;
	logic       use_mem_q;
	logic       claimed_q;

	logic [15:0] pm;
	logic        is_ext;
	logic        mono_pair;
	logic        gate;
	logic        in_file;
	logic [AW-1:0] addr;
	logic        mem_we;
	logic [7:0]  rd_n;
	logic        use_mem_n;
	logic        claimed_n;

	logic [7:0]  rd_out;
	logic        mapped;
	logic        dual;
	logic [19:0] off0;
	logic [19:0] off1;
	logic [19:0] single_off;
	logic [19:0] lo_off;
	logic [19:0] hi_off;

	// Capture the beat; fields from the lowest bit up.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_tuser[0];
			port_q  <= s_tdata[15:0];
			wd_q    <= s_tdata[23:16];
			c4_q    <= s_tdata[24];
			mm_q    <= s_tdata[26:25];
			color_q <= s_tdata[27];
		end
	end

	// Mono addressing moves the 0x3Bx and 0x3Dx groups onto each other.
	always_comb begin
		pm = port_q;
		if ((port_q[15:4] == vgaxm_pkg::MONO_GROUP || port_q[15:4] == vgaxm_pkg::COLOR_GROUP)
				&& !color_q) begin
			pm = port_q ^ vgaxm_pkg::MONO_XOR;
		end
	end

	assign mono_pair = (pm[15:1] == vgaxm_pkg::PORT_MONO_IDX[15:1]);
	assign is_ext    = mono_pair || (pm[15:1] == vgaxm_pkg::PORT_COLOR_IDX[15:1]);
	assign gate      = (xsetup_q[vgaxm_pkg::ENABLE_BIT] || x70_q)
		&& (mono_pair ? xsetup_q[vgaxm_pkg::SELECT_BIT] : !xsetup_q[vgaxm_pkg::SELECT_BIT]);
	assign in_file   = ({1'b0, idx_q} < DEPTH);
	assign addr      = idx_q[AW-1:0];
	assign mem_we    = cmd.exec && is_ext && gate && mode_q && pm[0] && in_file;

	// Read data and claim for the decoded port.
	always_comb begin
		rd_n      = vgaxm_pkg::IDLE_BYTE;
		use_mem_n = 1'b0;
		claimed_n = 1'b0;
		if (is_ext) begin
			claimed_n = 1'b1;
			if (gate && !mode_q) begin
				if (!pm[0]) begin
					rd_n = idx_q;
				end else if (idx_q == vgaxm_pkg::IDX_VERSION) begin
					rd_n = vgaxm_pkg::VERSION_BYTE;
				end else if (idx_q == vgaxm_pkg::IDX_CONFIG) begin
					rd_n = vgaxm_pkg::CONFIG_BYTE;
				end else if (in_file) begin
					use_mem_n = 1'b1;
				end
			end
		end else if (pm == vgaxm_pkg::PORT_SETUP) begin
			claimed_n = 1'b1;
			rd_n      = {7'd0, setup_q[3]};
		end else if (pm == vgaxm_pkg::PORT_XSETUP) begin
			claimed_n = 1'b1;
			rd_n      = xsetup_q;
		end else if (pm == vgaxm_pkg::PORT_ID) begin
			claimed_n = 1'b1;
			rd_n      = vgaxm_pkg::ID_BYTE;
		end else if (pm == vgaxm_pkg::PORT_OPTSEL && mode_q) begin
			claimed_n = 1'b1;
		end
	end

	// Decode results.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q      <= rd_n;
			use_mem_q <= use_mem_n;
			claimed_q <= claimed_n;
		end
	end

	// Register file storage with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (mem_we) begin
				mem[addr] <= wd_q;
			end
			mem_rd_q <= mem[addr];
		end
	end

	// State updates on write accesses; shadow copies of the fixed registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			setup_q   <= '0;
			xsetup_q  <= '0;
			x0b_q     <= '0;
			x0c_q     <= 1'b0;
			x10_q     <= '0;
			x11_q     <= '0;
			x28_q     <= 1'b0;
			x70_q     <= 1'b0;
			vld_q     <= '0;
			mem_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			mem_vld_q <= vld_q[addr];
			if (mem_we) begin
				vld_q[addr] <= 1'b1;
				if (idx_q == vgaxm_pkg::REG_MAP)       x0b_q <= wd_q[2:0];
				if (idx_q == vgaxm_pkg::REG_START)     x0c_q <= wd_q[0];
				if (idx_q == vgaxm_pkg::REG_BANK0)     x10_q <= wd_q;
				if (idx_q == vgaxm_pkg::REG_BANK1)     x11_q <= wd_q;
				if (idx_q == vgaxm_pkg::REG_INTERLACE) x28_q <= wd_q[5];
				if (idx_q == vgaxm_pkg::REG_ENABLE)    x70_q <= wd_q[7];
			end
			if (mode_q) begin
				if (is_ext && gate && !pm[0]) begin
					idx_q <= wd_q;
				end else if (pm == vgaxm_pkg::PORT_SETUP) begin
					setup_q[3] <= wd_q[0];
				end else if (pm == vgaxm_pkg::PORT_XSETUP) begin
					xsetup_q <= wd_q;
				end else if (pm == vgaxm_pkg::PORT_OPTSEL) begin
					setup_q <= wd_q;
				end
			end
		end
	end

	// Bank offsets: a 4 KiB unit in chain-4 mode, else 1 KiB.
	assign off0 = c4_q ? {x10_q, 12'd0} : {2'd0, x10_q, 10'd0};
	assign off1 = c4_q ? {x11_q, 12'd0} : {2'd0, x11_q, 10'd0};
	assign mapped     = x0b_q[0];
	assign dual       = mapped && x0b_q[1] && (mm_q <= 2'd1);
	assign single_off = (mapped && !dual) ? off0 : 20'd0;
	assign lo_off     = dual ? off0 : 20'd0;
	assign hi_off     = dual ? off1 : 20'd0;

	// Writes return zero; a never-written register reads as its reset value.
	always_comb begin
		if (mode_q) begin
			rd_out = 8'd0;
		end else if (use_mem_q) begin
			rd_out = mem_vld_q ? mem_rd_q : 8'd0;
		end else begin
			rd_out = rd_q;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.form) begin
			m_tdata <= {7'd0, x0c_q, x28_q, x0b_q[2], dual, hi_off, lo_off, single_off,
				claimed_q, rd_out};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vga_extension_register_bank_mapper.sv
// VGA extension register bank mapper: takes one I/O read or write a beat and
// returns one result beat with read data, claim flag, bank offsets and display bits.
// Each access is captured, decoded with a registered read of the extension
// register file, then loaded into the result register, which waits while a stalled
// beat is held; a new beat is taken only after that load. The result register
// holds a finished beat while the next access is taken. After reset the register
// file reads as zero at once through per-entry valid bits; no clearing pass runs.
// Depends on vgaxm_pkg, vgaxm_ctrl and vgaxm_datapath.
`default_nettype none

module vga_extension_register_bank_mapper #(
	parameter int XREG_DEPTH = vgaxm_pkg::XREG_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// port[15:0], write_data[23:16], chain4_on[24], map_select[26:25],
	// color_addressing[27], zero fill above
	input  wire logic [vgaxm_pkg::S_TDATA_W-1:0]  s_tdata,
	// mode[0]: 0 read, 1 write
	input  wire logic [0:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// read_data[7:0], port_claimed[8], single_bank_offset[28:9],
	// low_half_offset[48:29], high_half_offset[68:49], dual_map[69],
	// chain4_packed[70], interlace_on[71], start_addr_bit16[72], zero fill above
	output logic      [vgaxm_pkg::M_TDATA_W-1:0]  m_tdata
);

	vgaxm_pkg::cmd_t cmd;

	vgaxm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	vgaxm_datapath #(
		.XREG_DEPTH (XREG_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

FILE: rtl/vgaxm_checker.sv
// Port-level checks for the VGA extension register bank mapper, bound to the top level.
// Depends on vgaxm_pkg for the beat widths.
`default_nettype none

module vgaxm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [vgaxm_pkg::M_TDATA_W-1:0]  m_tdata
);

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// One access at a time: no beat is taken right after another.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an access is in progress");

	// An unclaimed access reads all ones, or zero on a write.
	a_unclaimed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> (m_tdata[7:0] == 8'hFF || m_tdata[7:0] == 8'h00))
		else $error("unclaimed access returned data");

	// Single and dual mapping exclude each other.
	a_maps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[69] ? (m_tdata[28:9] == 20'd0)
			: (m_tdata[48:29] == 20'd0 && m_tdata[68:49] == 20'd0)))
		else $error("single and dual bank offsets both set");

	// Offsets are whole 1 KiB units.
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18:9] == 10'd0 && m_tdata[38:29] == 10'd0
			&& m_tdata[58:49] == 10'd0))
		else $error("bank offset not a multiple of the unit");

endmodule

bind vga_extension_register_bank_mapper vgaxm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the VGA extension register bank mapper.
// Drives I/O access beats, predicts every result beat and compares them field by field.
// Depends on vgaxm_pkg and vga_extension_register_bank_mapper.
`default_nettype none

module tb;

	// Access kinds carried in s_tuser.
	localparam bit ACC_READ  = 1'b0;
	localparam bit ACC_WRITE = 1'b1;

	// Bank granularity in bytes.
	localparam int UNIT_CHAIN4 = 4096;
	localparam int UNIT_PLANAR = 1024;

	// Cycles without any beat before the run is abandoned, and the settling time at the end.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 12;

	typedef struct {
		bit          wr;
		logic [15:0] port;
		logic [7:0]  wdata;
		bit          chain4;
		logic [1:0]  map_mode;
		bit          colour;
	} access_t;

	typedef struct {
		logic [7:0]  read_data;
		logic        claimed;
		logic [19:0] single_off;
		logic [19:0] low_off;
		logic [19:0] high_off;
		logic        dual;
		logic        packed_c4;
		logic        interlace;
		logic        start16;
	} outcome_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [vgaxm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [0:0]                      s_tuser  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [vgaxm_pkg::M_TDATA_W-1:0] m_tdata;

	int send_idle_pct  = 12;
	int recv_idle_pct  = 72;
	int mismatch_count = 0;
	int idle_cycles    = 0;

	// Shadow of the block state, zero as after reset.
	bit [7:0] xregs [256];
	bit [7:0] xindex;
	bit [7:0] setup_reg;
	bit [7:0] xsetup;

	outcome_t expected_outcomes [$];

	vga_extension_register_bank_mapper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random with the current idle share.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Registers beyond the file read as zero.
	function automatic bit [7:0] xreg_value(input int idx);
		return (idx < vgaxm_pkg::XREG_DEPTH_DEF) ? xregs[idx] : 8'h00;
	endfunction

	// Applies one access to the shadow state and works out the result beat it gives.
	function automatic outcome_t predict_access(input access_t a);
		logic [15:0] p;
		logic [7:0]  rd;
		logic [7:0]  en_reg;
		logic [7:0]  map;
		logic [7:0]  bank0;
		logic [7:0]  bank1;
		logic [7:0]  ilace;
		logic [7:0]  start;
		bit          claimed;
		bit          gate_open;
		bit          dual;
		int unsigned unit;
		int unsigned single;
		int unsigned lo;
		int unsigned hi;
		outcome_t    o;

		p = a.port;
		if ((p[15:4] == vgaxm_pkg::MONO_GROUP || p[15:4] == vgaxm_pkg::COLOR_GROUP)
				&& !a.colour)
			p = p ^ vgaxm_pkg::MONO_XOR;
		rd = vgaxm_pkg::IDLE_BYTE;
		claimed = 1'b0;

		if ({p[15:1], 1'b0} == vgaxm_pkg::PORT_MONO_IDX
				|| {p[15:1], 1'b0} == vgaxm_pkg::PORT_COLOR_IDX) begin
			claimed = 1'b1;
			en_reg = xreg_value(int'(vgaxm_pkg::REG_ENABLE));
			gate_open = (xsetup[vgaxm_pkg::ENABLE_BIT] || en_reg[vgaxm_pkg::ENABLE_BIT]) &&
				((p[15:4] == vgaxm_pkg::MONO_GROUP) ? xsetup[vgaxm_pkg::SELECT_BIT]
					: !xsetup[vgaxm_pkg::SELECT_BIT]);
			if (gate_open) begin
				if (a.wr) begin
					if (!p[0])
						xindex = a.wdata;
					else if (int'(xindex) < vgaxm_pkg::XREG_DEPTH_DEF)
						xregs[xindex] = a.wdata;
				end else if (!p[0]) begin
					rd = xindex;
				end else if (xindex == vgaxm_pkg::IDX_VERSION) begin
					rd = vgaxm_pkg::VERSION_BYTE;
				end else if (xindex == vgaxm_pkg::IDX_CONFIG) begin
					rd = vgaxm_pkg::CONFIG_BYTE;
				end else if (int'(xindex) < vgaxm_pkg::XREG_DEPTH_DEF) begin
					rd = xregs[xindex];
				end
			end
		end else if (p == vgaxm_pkg::PORT_SETUP) begin
			claimed = 1'b1;
			if (a.wr)
				setup_reg[3] = a.wdata[0];
			else
				rd = {7'b0, setup_reg[3]};
		end else if (p == vgaxm_pkg::PORT_XSETUP) begin
			claimed = 1'b1;
			if (a.wr)
				xsetup = a.wdata;
			else
				rd = xsetup;
		end else if (p == vgaxm_pkg::PORT_ID) begin
			claimed = 1'b1;
			if (!a.wr)
				rd = vgaxm_pkg::ID_BYTE;
		end else if (p == vgaxm_pkg::PORT_OPTSEL && a.wr) begin
			claimed = 1'b1;
			setup_reg = a.wdata;
		end

		// Bank windows follow the register file as it stands after the access.
		unit = a.chain4 ? UNIT_CHAIN4 : UNIT_PLANAR;
		map = xreg_value(int'(vgaxm_pkg::REG_MAP));
		bank0 = xreg_value(int'(vgaxm_pkg::REG_BANK0));
		bank1 = xreg_value(int'(vgaxm_pkg::REG_BANK1));
		ilace = xreg_value(int'(vgaxm_pkg::REG_INTERLACE));
		start = xreg_value(int'(vgaxm_pkg::REG_START));
		single = 0;
		lo = 0;
		hi = 0;
		dual = 1'b0;
		if (map[0]) begin
			if (map[1] && a.map_mode <= 2'd1) begin
				dual = 1'b1;
				lo = unit * 32'(bank0);
				hi = unit * 32'(bank1);
			end else begin
				single = unit * 32'(bank0);
			end
		end

		o.read_data  = a.wr ? 8'h00 : rd;
		o.claimed    = claimed;
		o.single_off = single[19:0];
		o.low_off    = lo[19:0];
		o.high_off   = hi[19:0];
		o.dual       = dual;
		o.packed_c4  = map[2];
		o.interlace  = ilace[5];
		o.start16    = start[0];
		return o;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// Checks each result beat against the oldest prediction, then predicts each accepted access.
	always @(posedge clk) begin : monitor
		access_t  a;
		outcome_t got;
		outcome_t want;

		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.read_data  = m_tdata[7:0];
				got.claimed    = m_tdata[8];
				got.single_off = m_tdata[28:9];
				got.low_off    = m_tdata[48:29];
				got.high_off   = m_tdata[68:49];
				got.dual       = m_tdata[69];
				got.packed_c4  = m_tdata[70];
				got.interlace  = m_tdata[71];
				got.start16    = m_tdata[72];
				if (expected_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result beat with nothing expected: %h", m_tdata);
				end else begin
					want = expected_outcomes.pop_front();
					check_field("read_data", 32'(want.read_data), 32'(got.read_data));
					check_field("port_claimed", 32'(want.claimed), 32'(got.claimed));
					check_field("single_bank_offset", 32'(want.single_off),
						32'(got.single_off));
					check_field("low_half_offset", 32'(want.low_off), 32'(got.low_off));
					check_field("high_half_offset", 32'(want.high_off), 32'(got.high_off));
					check_field("dual_map", 32'(want.dual), 32'(got.dual));
					check_field("packed_c4", 32'(want.packed_c4), 32'(got.packed_c4));
					check_field("interlace_on", 32'(want.interlace), 32'(got.interlace));
					check_field("start_addr_bit16", 32'(want.start16), 32'(got.start16));
				end
			end
			if (s_tvalid && s_tready) begin
				a.port     = s_tdata[15:0];
				a.wdata    = s_tdata[23:16];
				a.chain4   = s_tdata[24];
				a.map_mode = s_tdata[26:25];
				a.colour   = s_tdata[27];
				a.wr       = s_tuser[0];
				expected_outcomes.push_back(predict_access(a));
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Presents one access beat, after a random gap, and returns at the edge that takes it.
	task automatic send_access(input bit wr, input logic [15:0] port, input logic [7:0] wdata,
			input bit colour, input bit chain4, input logic [1:0] map_mode);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, colour, map_mode, chain4, wdata, port};
		s_tuser  <= wr;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and waits until every predicted beat has come back.
	task automatic hold_until_drained;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Setup, option-select and identification ports, and an unclaimed port.
	task automatic test_fixed_ports;
		send_access(ACC_READ, vgaxm_pkg::PORT_ID, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_ID, 8'h5A, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_OPTSEL, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_OPTSEL, 8'hFF, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_SETUP, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_SETUP, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 2'd3);
	endtask

	// Gated and open extension accesses, fixed index reads and the file-held enable.
	task automatic test_extension_gate;
		send_access(ACC_READ, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_XSETUP, 8'h80, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX, vgaxm_pkg::IDX_CONFIG,
			1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_XSETUP, 8'hC0, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h00, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_MONO_IDX, vgaxm_pkg::REG_ENABLE,
			1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_MONO_IDX | 16'h1, 8'h80, 1'b1, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_XSETUP, 8'h40, 1'b1, 1'b0, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_MONO_IDX | 16'h1, 8'h00, 1'b1, 1'b0, 2'd0);
	endtask

	// Dual and single windows at full scale, reached through mono address swapping.
	task automatic test_bank_windows;
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX, vgaxm_pkg::REG_MAP,
			1'b0, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h07, 1'b0, 1'b0, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX, vgaxm_pkg::REG_BANK0,
			1'b0, 1'b0, 2'd1);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'hFF, 1'b0, 1'b0, 2'd1);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX, vgaxm_pkg::REG_BANK1,
			1'b0, 1'b1, 2'd0);
		send_access(ACC_WRITE, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'hFF, 1'b0, 1'b1, 2'd0);
		send_access(ACC_READ, vgaxm_pkg::PORT_COLOR_IDX | 16'h1, 8'h00, 1'b0, 1'b1, 2'd2);
	endtask

	// Mostly index-then-data sequences on the extension pairs, with setup traffic and noise.
	task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
		int          sent;
		int          pick;
		bit          colour;
		logic [15:0] pair;
		logic [15:0] port;
		logic [7:0]  idx;

		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			colour = bit'($urandom_range(1));
			pair = $urandom_range(1) ? vgaxm_pkg::PORT_MONO_IDX : vgaxm_pkg::PORT_COLOR_IDX;
			if (pick < 45) begin
				if ($urandom_range(1)) begin
					case ($urandom_range(7))
						0: idx = vgaxm_pkg::IDX_VERSION;
						1: idx = vgaxm_pkg::IDX_CONFIG;
						2: idx = vgaxm_pkg::REG_MAP;
						3: idx = vgaxm_pkg::REG_START;
						4: idx = vgaxm_pkg::REG_BANK0;
						5: idx = vgaxm_pkg::REG_BANK1;
						6: idx = vgaxm_pkg::REG_INTERLACE;
						default: idx = vgaxm_pkg::REG_ENABLE;
					endcase
				end else begin
					idx = 8'($urandom);
				end
				send_access(ACC_WRITE, pair, idx, colour,
					bit'($urandom_range(1)), 2'($urandom_range(3)));
				send_access(bit'($urandom_range(1)), pair | 16'h1, 8'($urandom), colour,
					bit'($urandom_range(1)), 2'($urandom_range(3)));
				sent += 2;
			end else begin
				if (pick < 55) begin
					port = pair | 16'($urandom_range(1));
					idx = 8'($urandom);
				end else if (pick < 65) begin
					// Extension setup writes keep the enable bit set most of the time.
					port = vgaxm_pkg::PORT_XSETUP;
					idx = {($urandom_range(9) < 8), 7'($urandom)};
				end else if (pick < 80) begin
					case ($urandom_range(3))
						0: port = vgaxm_pkg::PORT_SETUP;
						1: port = vgaxm_pkg::PORT_XSETUP;
						2: port = vgaxm_pkg::PORT_ID;
						default: port = vgaxm_pkg::PORT_OPTSEL;
					endcase
					idx = 8'($urandom);
				end else begin
					if ($urandom_range(1))
						port = 16'($urandom);
					else
						port = {4'h0, ($urandom_range(1) ? vgaxm_pkg::MONO_GROUP[7:0]
							: vgaxm_pkg::COLOR_GROUP[7:0]), 4'($urandom)};
					idx = 8'($urandom);
				end
				if (pick >= 55 && pick < 65)
					send_access(ACC_WRITE, port, idx, colour,
						bit'($urandom_range(1)), 2'($urandom_range(3)));
				else
					send_access(bit'($urandom_range(1)), port, idx, colour,
						bit'($urandom_range(1)), 2'($urandom_range(3)));
				sent++;
			end
		end
	endtask

	// Ends the run when no beat has moved for too long.
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Test sequence.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_ports;
		test_extension_gate;
		test_bank_windows;
		test_random_traffic(520, 12, 72);
		hold_until_drained;
		test_random_traffic(520, 72, 12);
		hold_until_drained;
		test_random_traffic(500, 0, 0);

		hold_until_drained;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_outcomes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
